FILE: sv/mma_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and the reciprocal table of the multichannel moving-average filter.
// No dependencies; every other file of the block but mma_ram imports this package.
package mma_pkg;

   // Fixed sizes of the block.
   localparam int MAX_WINDOW    = 16;
   localparam int CHANNELS      = 10;
   localparam int SAMPLE_BITS   = 16;
   localparam int CSR_DATA_BITS = 5;
   localparam int CSR_INDEX_BITS = 1;

   // Derived widths.
   localparam int CH_BITS    = $clog2(CHANNELS);
   localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
   localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS   = SAMPLE_BITS + SLOT_BITS;
   localparam int HIST_DEPTH = CHANNELS * MAX_WINDOW;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Register indexes and reset values.
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENABLE = 1'b1;
   localparam logic [CSR_DATA_BITS-1:0]  WINDOW_RESET = 5'd3;

   // Division by the sample count is a multiply by ceil(2^RECIP_SHIFT / count).
   // With sums below 2^SUM_BITS and counts up to MAX_WINDOW the result is exact.
   localparam int RECIP_SHIFT = SUM_BITS + SLOT_BITS + 1;
   localparam int RECIP_BITS  = RECIP_SHIFT + 1;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

   typedef logic [SAMPLE_BITS-1:0]       sample_type;
   typedef sample_type [CHANNELS-1:0]    sample_vec_type;
   typedef logic [RECIP_BITS-1:0]        recip_type;

   // Entry n holds the reciprocal of the count n + 1.
   localparam recip_type RECIP_TABLE [MAX_WINDOW] = '{
      26'd33554432, 26'd16777216, 26'd11184811, 26'd8388608,
      26'd6710887,  26'd5592406,  26'd4793491,  26'd4194304,
      26'd3728271,  26'd3355444,  26'd3050403,  26'd2796203,
      26'd2581111,  26'd2396746,  26'd2236963,  26'd2097152
   };

   // One classified item as handed from the front to the back.
   typedef struct packed {
      logic                 bypass;
      logic [SLOT_BITS-1:0] slot;
      logic                 full;
      logic [WIN_BITS-1:0]  held;
      sample_vec_type       samples;
   } entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ISSUE,
      BACK_DRAIN
   } back_state_type;

   // History address of one channel's slot.
   function automatic logic [HIST_AW-1:0] hist_addr(input logic [CH_BITS-1:0] ch,
                                                    input logic [SLOT_BITS-1:0] slot);
      hist_addr = HIST_AW'(ch) * HIST_AW'(MAX_WINDOW) + HIST_AW'(slot);
   endfunction

endpackage

FILE: sv/mma_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 160
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/mma_div.sv
`timescale 1ns / 1ps
// Mean unit: divides a channel sum by the sample count through a reciprocal multiply.
// Depends on mma_pkg for widths and the reciprocal table; the product is registered.
module mma_div import mma_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [CH_BITS-1:0]  in_ch,
   input  logic [SUM_BITS-1:0] in_sum,
   input  logic [WIN_BITS-1:0] in_held,
   output logic                out_valid,
   output logic [CH_BITS-1:0]  out_ch,
   output sample_type          out_mean
);

   logic                 valid_ff;
   logic [CH_BITS-1:0]   ch_ff;
   logic [PROD_BITS-1:0] prod_ff;
   logic [PROD_BITS-1:0] prod_in;
   logic [SLOT_BITS-1:0] recip_idx;

   // The count is at least one, so count - 1 indexes the table.
   assign recip_idx = SLOT_BITS'(in_held - WIN_BITS'(1));
   assign prod_in   = PROD_BITS'(in_sum) * PROD_BITS'(RECIP_TABLE[recip_idx]);

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Product register.
   always_ff @(posedge clock) begin
      ch_ff   <= in_ch;
      prod_ff <= prod_in;
   end

   assign out_valid = valid_ff;
   assign out_ch    = ch_ff;
   assign out_mean  = prod_ff[RECIP_SHIFT +: SAMPLE_BITS];

endmodule

FILE: sv/mma_queue.sv
`timescale 1ns / 1ps
// Short queue of classified items between the front and the back.
// Depends on mma_pkg for the entry type and the depth.
module mma_queue import mma_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);

   entry_type                 slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;

   assign full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slots_ff[rd_ptr_ff];

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: sv/mma_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, input transfers and window bookkeeping per item.
// Depends on mma_pkg; feeds classified items into mma_queue.
module mma_front import mma_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sample_vec_type            req_samples,
   input  logic                      queue_full,
   output logic                      push,
   output entry_type                 push_entry,
   output logic                      hist_clear
);

   logic [CSR_DATA_BITS-1:0] window_ff;
   logic                     enable_ff;
   logic [WIN_BITS-1:0]      fill_ff;
   logic [SLOT_BITS-1:0]     slot_ff;

   logic [WIN_BITS-1:0]      win;
   logic [SLOT_BITS-1:0]     cur_slot;
   logic                     full;
   logic [WIN_BITS-1:0]      held;
   logic [SLOT_BITS-1:0]     slot_in;

   // Effective window: zero counts as one, large values saturate.
   always_comb begin
      if (window_ff == '0) begin
         win = WIN_BITS'(1);
      end else if (window_ff > CSR_DATA_BITS'(MAX_WINDOW)) begin
         win = WIN_BITS'(MAX_WINDOW);
      end else begin
         win = WIN_BITS'(window_ff);
      end
   end

   // Slot and sample count for the item in this transfer.
   assign cur_slot = (WIN_BITS'(slot_ff) >= win) ? '0 : slot_ff;
   assign full     = (fill_ff >= win);
   assign held     = full ? win : fill_ff + 1'b1;
   assign slot_in  = (WIN_BITS'(cur_slot) + 1'b1 >= win) ? '0 : cur_slot + 1'b1;

   assign req_ready  = !queue_full;
   assign push       = req_valid && req_ready;
   assign hist_clear = csr_write && (csr_index == REG_WINDOW);

   always_comb begin
      push_entry.bypass  = !enable_ff;
      push_entry.slot    = cur_slot;
      push_entry.full    = full;
      push_entry.held    = held;
      push_entry.samples = req_samples;
   end

   // Registers, history bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         enable_ff <= 1'b1;
         fill_ff   <= '0;
         slot_ff   <= '0;
      end else begin
         if (csr_write && csr_index == REG_WINDOW) begin
            window_ff <= csr_wdata;
            fill_ff   <= '0;
            slot_ff   <= '0;
         end else if (push && enable_ff) begin
            fill_ff <= held;
            slot_ff <= slot_in;
         end
         if (csr_write && csr_index == REG_ENABLE) begin
            enable_ff <= csr_wdata[0];
         end
      end
   end

`ifndef SYNTHESIS
   // The held count never exceeds the effective window.
   assert property (@(posedge clock) disable iff (reset) fill_ff <= win)
      else $error("fill count above window");

   // A window write restarts the history.
   assert property (@(posedge clock) disable iff (reset)
      hist_clear |=> (fill_ff == '0) && (slot_ff == '0))
      else $error("history not cleared after window write");
`endif

endmodule

FILE: sv/mma_back.sv
`timescale 1ns / 1ps
// Back end: walks the channels of one item through the history RAM, sums and mean unit.
// Depends on mma_pkg, mma_ram and mma_div.
module mma_back import mma_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           hist_clear,
   input  logic           queue_valid,
   input  entry_type      queue_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output sample_vec_type rsp_mean
);

   back_state_type      state_ff;
   back_state_type      state_in;
   entry_type           cur_ff;
   logic [CH_BITS-1:0]  rd_ch_ff;
   logic                s1_valid_ff;
   logic [CH_BITS-1:0]  s1_ch_ff;
   logic [SUM_BITS-1:0] sums_ff [CHANNELS];
   sample_vec_type      mean_ff;
   logic                rsp_valid_ff;

   sample_type          hist_rd;
   sample_type          old_sample;
   sample_type          new_sample;
   logic [SUM_BITS-1:0] sum_new;
   logic                div_valid;
   logic [CH_BITS-1:0]  div_ch;
   sample_type          div_mean;
   logic                last_done;

   localparam logic [CH_BITS-1:0] LAST_CH = CH_BITS'(CHANNELS - 1);

   assign pop       = (state_ff == BACK_IDLE) && queue_valid && !rsp_valid_ff;
   assign last_done = div_valid && (div_ch == LAST_CH);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (pop && !queue_entry.bypass) begin
               state_in = BACK_ISSUE;
            end
         end
         BACK_ISSUE: begin
            if (rd_ch_ff == LAST_CH) begin
               state_in = BACK_DRAIN;
            end
         end
         BACK_DRAIN: begin
            if (last_done) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // History: read one channel's oldest slot, write the new sample in the following cycle.
   mma_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(HIST_DEPTH)
   ) u_hist (
      .clock  (clock),
      .wr_en  (s1_valid_ff),
      .wr_addr(hist_addr(s1_ch_ff, cur_ff.slot)),
      .wr_data(new_sample),
      .rd_addr(hist_addr(rd_ch_ff, cur_ff.slot)),
      .rd_data(hist_rd)
   );

   // Sum update for the channel whose history word has arrived.
   assign new_sample = cur_ff.samples[s1_ch_ff];
   assign old_sample = cur_ff.full ? hist_rd : '0;
   assign sum_new    = sums_ff[s1_ch_ff] - SUM_BITS'(old_sample) + SUM_BITS'(new_sample);

   mma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_ch    (s1_ch_ff),
      .in_sum   (sum_new),
      .in_held  (cur_ff.held),
      .out_valid(div_valid),
      .out_ch   (div_ch),
      .out_mean (div_mean)
   );

   // Control registers: channel sequencing, running sums, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ch_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff <= (state_ff == BACK_ISSUE);
         if (pop) begin
            rd_ch_ff <= '0;
         end else if (state_ff == BACK_ISSUE) begin
            rd_ch_ff <= rd_ch_ff + 1'b1;
         end
         if (hist_clear) begin
            for (int i = 0; i < CHANNELS; i++) begin
               sums_ff[i] <= '0;
            end
         end else if (s1_valid_ff) begin
            sums_ff[s1_ch_ff] <= sum_new;
         end
         if ((pop && queue_entry.bypass) || (state_ff == BACK_DRAIN && last_done)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: current item, stage channel, results.
   always_ff @(posedge clock) begin
      s1_ch_ff <= rd_ch_ff;
      if (pop) begin
         cur_ff <= queue_entry;
      end
      if (pop && queue_entry.bypass) begin
         mean_ff <= queue_entry.samples;
      end else if (div_valid) begin
         mean_ff[div_ch] <= div_mean;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mean  = mean_ff;

`ifndef SYNTHESIS
   // Means only come back while an item is being worked on.
   assert property (@(posedge clock) disable iff (reset)
      div_valid |-> (state_ff == BACK_ISSUE || state_ff == BACK_DRAIN))
      else $error("mean unit output outside of an item");

   // A result appears only after a bypass transfer or the last channel's mean.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(pop) || $past(state_ff == BACK_DRAIN)))
      else $error("result without a finished item");

   // The history write never hits the slot being read in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_ISSUE && s1_valid_ff) |-> (rd_ch_ff != s1_ch_ff))
      else $error("history read and write collide");
`endif

endmodule

FILE: sv/multichannel_moving_average_top.sv
`timescale 1ns / 1ps
// Top level of the ten-channel moving-average filter: ports, field packing, instances.
// Depends on mma_pkg, mma_front, mma_queue and mma_back.
//
// Each req_ transfer carries one 16-bit sample per sensor and yields exactly one rsp_
// transfer with each channel's mean over its last window_length samples (truncated;
// over fewer samples while the history fills), or the raw samples when filter_enable
// is 0. The front takes an item in the cycle it arrives while its two-entry queue has
// room, even while a result waits on rsp_ready. The back starts an item once the result
// register is empty, at the earliest on the edge after the item's req_ transfer: a
// filtered item walks the channels one per cycle through the history RAM's single read
// port and the shared reciprocal-multiply mean unit, and its result is valid once the
// last channel's mean has left the mean unit; a bypassed item's result is valid right
// after the edge at which it leaves the queue. The back works on one item at a time and
// takes the next only after the last result was taken. csr_write with csr_index 0
// sets the window and clears the history; index 1 sets the enable. Write them only while
// the block is idle. The history RAM needs no clearing pass: a slot's old value is used
// only after it was written since the last clear.
module multichannel_moving_average_top import mma_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [15:0]               req_front_left,
   input  logic [15:0]               req_front_center_left,
   input  logic [15:0]               req_front_center,
   input  logic [15:0]               req_front_center_right,
   input  logic [15:0]               req_front_right,
   input  logic [15:0]               req_side_left,
   input  logic [15:0]               req_side_right,
   input  logic [15:0]               req_rear_left,
   input  logic [15:0]               req_rear_center,
   input  logic [15:0]               req_rear_right,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [15:0]               rsp_mean_front_left,
   output logic [15:0]               rsp_mean_front_center_left,
   output logic [15:0]               rsp_mean_front_center,
   output logic [15:0]               rsp_mean_front_center_right,
   output logic [15:0]               rsp_mean_front_right,
   output logic [15:0]               rsp_mean_side_left,
   output logic [15:0]               rsp_mean_side_right,
   output logic [15:0]               rsp_mean_rear_left,
   output logic [15:0]               rsp_mean_rear_center,
   output logic [15:0]               rsp_mean_rear_right
);

   sample_vec_type req_samples;
   sample_vec_type rsp_means;
   entry_type      push_entry;
   entry_type      pop_entry;
   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_valid;
   logic           hist_clear;

   // Channel order of the sample vector.
   assign req_samples[0] = req_front_left;
   assign req_samples[1] = req_front_center_left;
   assign req_samples[2] = req_front_center;
   assign req_samples[3] = req_front_center_right;
   assign req_samples[4] = req_front_right;
   assign req_samples[5] = req_side_left;
   assign req_samples[6] = req_side_right;
   assign req_samples[7] = req_rear_left;
   assign req_samples[8] = req_rear_center;
   assign req_samples[9] = req_rear_right;

   assign rsp_mean_front_left         = rsp_means[0];
   assign rsp_mean_front_center_left  = rsp_means[1];
   assign rsp_mean_front_center       = rsp_means[2];
   assign rsp_mean_front_center_right = rsp_means[3];
   assign rsp_mean_front_right        = rsp_means[4];
   assign rsp_mean_side_left          = rsp_means[5];
   assign rsp_mean_side_right         = rsp_means[6];
   assign rsp_mean_rear_left          = rsp_means[7];
   assign rsp_mean_rear_center        = rsp_means[8];
   assign rsp_mean_rear_right         = rsp_means[9];

   mma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_samples(req_samples),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry),
      .hist_clear (hist_clear)
   );

   mma_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (queue_valid),
      .pop_entry (pop_entry)
   );

   mma_back u_back (
      .clock      (clock),
      .reset      (reset),
      .hist_clear (hist_clear),
      .queue_valid(queue_valid),
      .queue_entry(pop_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_mean   (rsp_means)
   );

endmodule
